// ===== design/line_sensor_calibrate_normalize_top_defines.svh =====
// Assertion macros shared by the checker.
`ifndef LINE_SENSOR_CALIBRATE_NORMALIZE_TOP_DEFINES_SVH
`define LINE_SENSOR_CALIBRATE_NORMALIZE_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LSCN_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lscn: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define LSCN_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lscn: next-cycle check failed");

`endif

// ===== design/lscn_pkg.sv =====
package lscn_pkg;

  localparam int SENSORS_DEF = 5;
  localparam int SENSOR_W    = 3;
  localparam int VAL_W       = 8;
  localparam int PROD_W      = 2 * VAL_W;

  localparam logic [VAL_W-1:0] UNCAL_LEVEL    = 8'd128;
  localparam logic [VAL_W-1:0] FULL_SCALE_RST = 8'd255;
  localparam logic [VAL_W-1:0] MIN_RANGE_RST  = 8'd50;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_NORM   = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_FULL_SCALE = 1'b0;
  localparam logic REG_MIN_RANGE  = 1'b1;

  typedef struct packed {
    logic [1:0]          op;
    logic [SENSOR_W-1:0] sensor;
    logic [VAL_W-1:0]    raw_value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] level;
    logic             sensor_calibrated;
    logic             all_calibrated;
    logic [VAL_W-1:0] low_mark;
    logic [VAL_W-1:0] high_mark;
    logic [VAL_W-1:0] span;
    logic             index_valid;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0] low_mark;
    logic [VAL_W-1:0] high_mark;
    logic [VAL_W-1:0] span;
  } bank_entry_t;

  typedef struct packed {
    logic                clear;
    logic                sample;
    logic [SENSOR_W-1:0] sensor;
    logic [VAL_W-1:0]    raw;
  } bank_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic bank_entry_t preset_entry(input logic [SENSOR_W-1:0] idx);
    bank_entry_t e;
    case (idx)
      3'd0:    e = '{low_mark: 8'd3,   high_mark: 8'd121, span: 8'd118};
      3'd1:    e = '{low_mark: 8'd5,   high_mark: 8'd102, span: 8'd97};
      3'd2:    e = '{low_mark: 8'd5,   high_mark: 8'd68,  span: 8'd63};
      3'd3:    e = '{low_mark: 8'd9,   high_mark: 8'd106, span: 8'd97};
      3'd4:    e = '{low_mark: 8'd25,  high_mark: 8'd202, span: 8'd177};
      default: e = '{low_mark: 8'd255, high_mark: 8'd0,   span: 8'd0};
    endcase
    return e;
  endfunction

endpackage

// ===== design/lscn_bank.sv =====
module lscn_bank #(
  parameter int SENSORS = lscn_pkg::SENSORS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lscn_pkg::bank_cmd_t                cmd,
  input  logic [lscn_pkg::VAL_W-1:0]         full_scale,
  input  logic [lscn_pkg::VAL_W-1:0]         min_range,
  input  logic [lscn_pkg::SENSOR_W-1:0]      rd_sensor,
  output lscn_pkg::bank_entry_t              rd_entry,
  output logic                               all_cal
);

  localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [lscn_pkg::SENSOR_W:0] SENSOR_CNT = (lscn_pkg::SENSOR_W + 1)'(SENSORS);

  lscn_pkg::bank_entry_t entry_r [SENSORS];
  lscn_pkg::bank_entry_t cur;
  lscn_pkg::bank_entry_t upd;
  logic [IDX_W-1:0]      wr_idx;
  logic [lscn_pkg::VAL_W-1:0] diff;

  assign wr_idx = cmd.sensor[IDX_W-1:0];
  assign cur    = entry_r[wr_idx];

  // Widen the marks, accept the span once the distance is large enough
  always_comb begin
    upd = cur;
    if (cmd.raw < cur.low_mark) begin
      upd.low_mark = cmd.raw;
    end
    if (cmd.raw > cur.high_mark) begin
      upd.high_mark = cmd.raw;
    end
    diff = upd.high_mark - upd.low_mark;
    if ((upd.high_mark > upd.low_mark) && (diff >= min_range)) begin
      upd.span = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        entry_r[i] <= lscn_pkg::preset_entry(lscn_pkg::SENSOR_W'(i));
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < SENSORS; i++) begin
        entry_r[i] <= '{low_mark: full_scale, high_mark: '0, span: '0};
      end
    end else if (cmd.sample) begin
      entry_r[wr_idx] <= upd;
    end
  end

  always_comb begin
    if ({1'b0, rd_sensor} < SENSOR_CNT) begin
      rd_entry = entry_r[rd_sensor[IDX_W-1:0]];
    end else begin
      rd_entry = '0;
    end
  end

  always_comb begin
    all_cal = 1'b1;
    for (int i = 0; i < SENSORS; i++) begin
      if (entry_r[i].span == '0) begin
        all_cal = 1'b0;
      end
    end
  end

endmodule

// ===== design/lscn_div.sv =====
module lscn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lscn_pkg::PROD_W-1:0]   dividend,
  input  logic [lscn_pkg::VAL_W-1:0]    divisor,
  output logic                          done,
  output logic [lscn_pkg::PROD_W-1:0]   quotient
);

  localparam int STEPS = lscn_pkg::PROD_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [lscn_pkg::VAL_W-1:0]  rem_r, rem_nxt;
  logic [lscn_pkg::VAL_W-1:0]  dvs_r, dvs_nxt;
  logic [lscn_pkg::PROD_W-1:0] quo_r, quo_nxt;
  logic [lscn_pkg::VAL_W:0]    r1, r2;
  logic [lscn_pkg::VAL_W-1:0]  rem1;
  logic                        q1, q2;

  // Two restoring steps per cycle
  always_comb begin
    r1 = {rem_r, quo_r[lscn_pkg::PROD_W-1]};
    q1 = (r1 >= {1'b0, dvs_r});
    rem1 = q1 ? lscn_pkg::VAL_W'(r1 - {1'b0, dvs_r}) : r1[lscn_pkg::VAL_W-1:0];
    r2 = {rem1, quo_r[lscn_pkg::PROD_W-2]};
    q2 = (r2 >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = q2 ? lscn_pkg::VAL_W'(r2 - {1'b0, dvs_r}) : r2[lscn_pkg::VAL_W-1:0];
      quo_nxt = {quo_r[lscn_pkg::PROD_W-3:0], q1, q2};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/line_sensor_calibrate_normalize_top.sv =====
// Flow: an accepted transaction moves from the idle state through calc to done, where
//   its result is loaded and out_valid rises; this path serves clear, calibration,
//   op 3 and a normalize that does not divide. A normalize transaction that divides
//   also waits in the div state for the 2-bit-per-cycle divider to finish.
// One transaction in flight: in_ready is high only in the idle state, so the next
//   input transaction is accepted only after the previous result is loaded. A held
//   result stalls the sequencer in its done state until the result register frees up.
// Reset (rst_n low, synchronous): calibration bank loads its preset table,
//   full_scale 255, min_range 50, sequencer idle, no result pending.
module line_sensor_calibrate_normalize_top #(
  parameter int SENSORS = lscn_pkg::SENSORS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lscn_pkg::in_t         in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output lscn_pkg::out_t        out_data
);

  localparam logic [lscn_pkg::SENSOR_W:0] SENSOR_CNT = (lscn_pkg::SENSOR_W + 1)'(SENSORS);

  lscn_pkg::state_t state_r, state_nxt;

  lscn_pkg::in_t               item_r;
  logic [lscn_pkg::VAL_W-1:0]  full_scale_r;
  logic [lscn_pkg::VAL_W-1:0]  min_range_r;
  logic [lscn_pkg::VAL_W-1:0]  level_r, level_nxt;
  logic                        out_valid_r;
  lscn_pkg::out_t              out_data_r;

  lscn_pkg::bank_cmd_t         bank_cmd;
  lscn_pkg::bank_entry_t       entry;
  logic                        all_cal;
  logic                        idx_ok;
  logic                        need_div;
  logic                        div_start;
  logic                        div_done;
  logic [lscn_pkg::PROD_W-1:0] product;
  logic [lscn_pkg::PROD_W-1:0] quotient;
  logic                        in_xact;
  logic                        cfg_wr;
  logic                        out_load;
  lscn_pkg::out_t              result;

  // ---------------------------------------------------------------------------
  // Configuration registers: written in the APB access phase, read back as is
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= lscn_pkg::FULL_SCALE_RST;
      min_range_r  <= lscn_pkg::MIN_RANGE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        lscn_pkg::REG_FULL_SCALE: full_scale_r <= cfg_pwdata[lscn_pkg::VAL_W-1:0];
        lscn_pkg::REG_MIN_RANGE:  min_range_r  <= cfg_pwdata[lscn_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      lscn_pkg::REG_FULL_SCALE: cfg_prdata = {24'b0, full_scale_r};
      lscn_pkg::REG_MIN_RANGE:  cfg_prdata = {24'b0, min_range_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Capture the accepted transaction; it stays put until the result is formed
  // ---------------------------------------------------------------------------
  assign in_xact = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_xact) begin
      item_r <= in_data;
    end
  end

  assign idx_ok = ({1'b0, item_r.sensor} < SENSOR_CNT);

  // ---------------------------------------------------------------------------
  // Calibration bank: one addressed read, at most one update per transaction
  // ---------------------------------------------------------------------------
  lscn_bank #(
    .SENSORS (SENSORS)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (bank_cmd),
    .full_scale (full_scale_r),
    .min_range  (min_range_r),
    .rd_sensor  (item_r.sensor),
    .rd_entry   (entry),
    .all_cal    (all_cal)
  );

  // Only a normalize with a valid, calibrated sensor and a sample at or above the low
  // mark goes through the divider; the product is registered inside it.
  assign need_div = (item_r.op == lscn_pkg::OP_NORM) && (entry.span != '0) &&
                    (item_r.raw_value >= entry.low_mark);
  assign product  = lscn_pkg::PROD_W'(item_r.raw_value - entry.low_mark) *
                    lscn_pkg::PROD_W'(full_scale_r);

  lscn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (entry.span),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  assign out_load = (!out_valid_r) || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lscn_pkg::ST_IDLE: begin
        if (in_xact) begin
          state_nxt = lscn_pkg::ST_CALC;
        end
      end
      lscn_pkg::ST_CALC: begin
        state_nxt = (idx_ok && need_div) ? lscn_pkg::ST_DIV : lscn_pkg::ST_DONE;
      end
      lscn_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = lscn_pkg::ST_DONE;
        end
      end
      lscn_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = lscn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lscn_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready        = 1'b0;
    div_start       = 1'b0;
    bank_cmd.clear  = 1'b0;
    bank_cmd.sample = 1'b0;
    bank_cmd.sensor = item_r.sensor;
    bank_cmd.raw    = item_r.raw_value;
    level_nxt       = level_r;
    unique case (state_r)
      lscn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lscn_pkg::ST_CALC: begin
        // Apply the update, settle the easy levels, launch the divide
        bank_cmd.clear  = idx_ok && (item_r.op == lscn_pkg::OP_CLEAR);
        bank_cmd.sample = idx_ok && (item_r.op == lscn_pkg::OP_SAMPLE);
        div_start       = idx_ok && need_div;
        if (idx_ok && (item_r.op == lscn_pkg::OP_NORM) && (entry.span == '0)) begin
          level_nxt = lscn_pkg::UNCAL_LEVEL;
        end else begin
          level_nxt = '0;
        end
      end
      lscn_pkg::ST_DIV: begin
        // Saturate the quotient at full scale
        if (div_done) begin
          if (quotient > lscn_pkg::PROD_W'(full_scale_r)) begin
            level_nxt = full_scale_r;
          end else begin
            level_nxt = quotient[lscn_pkg::VAL_W-1:0];
          end
        end
      end
      lscn_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // Result reflects the bank after the update; an unknown sensor reports zeros
  always_comb begin
    result = '0;
    if (idx_ok) begin
      result.level             = level_r;
      result.sensor_calibrated = (entry.span != '0);
      result.all_calibrated    = all_cal;
      result.low_mark          = entry.low_mark;
      result.high_mark         = entry.high_mark;
      result.span              = entry.span;
      result.index_valid       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lscn_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == lscn_pkg::ST_DONE) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    if ((state_r == lscn_pkg::ST_DONE) && out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lscn_checker.sv =====
`include "line_sensor_calibrate_normalize_top_defines.svh"

module lscn_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lscn_pkg::out_t out_data
);

  logic in_xact;
  logic out_stall;
  logic bad_idx_zero;

  assign in_xact      = in_valid && in_ready;
  assign out_stall    = out_valid && !out_ready;
  assign bad_idx_zero = (out_data.level == '0) && !out_data.sensor_calibrated &&
                        !out_data.all_calibrated && (out_data.low_mark == '0) &&
                        (out_data.high_mark == '0) && (out_data.span == '0);

  // A stalled result holds
  `LSCN_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))

  // One transaction at a time: busy right after an acceptance
  `LSCN_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_xact, !in_ready)

  // Calibrated flag agrees with the reported span
  `LSCN_ASSERT_NOW(a_cal_flag, clk, rst_n, out_valid, out_data.sensor_calibrated == (out_data.span != '0))

  // An unknown sensor reports nothing but zeros
  `LSCN_ASSERT_NOW(a_bad_idx, clk, rst_n, out_valid && !out_data.index_valid, bad_idx_zero)

endmodule

bind line_sensor_calibrate_normalize_top lscn_checker u_lscn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_line_sensor_calibrate_normalize_top.sv =====
`timescale 1ns / 100ps

module tb_line_sensor_calibrate_normalize_top;
  import lscn_pkg::*;

  // Bank geometry as built; index slots past BANK exist only to take clears.
  localparam int BANK = SENSORS_DEF;
  localparam int SLOTS = 8;
  // The op encoding leaves one code unused; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 200;
  // Settle a little past the block's worst-case latency.
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_NS = 5_000_000;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;

  // Shadow copy of the calibration bank and the two registers, reset values included.
  logic [7:0] low_tab  [SLOTS] = '{8'd3, 8'd5, 8'd5, 8'd9, 8'd25, 8'd255, 8'd255, 8'd255};
  logic [7:0] high_tab [SLOTS] = '{8'd121, 8'd102, 8'd68, 8'd106, 8'd202, 8'd0, 8'd0, 8'd0};
  logic [7:0] span_tab [SLOTS] = '{8'd118, 8'd97, 8'd63, 8'd97, 8'd177, 8'd0, 8'd0, 8'd0};
  logic [7:0] fs_reg = FULL_SCALE_RST;
  logic [7:0] mr_reg = MIN_RANGE_RST;

  out_t     pending_results[$];
  dir_row_t directed_rows[$];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;

  line_sensor_calibrate_normalize_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // 10 ns clock: high half, low half.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transaction to the shadow bank and return the result it should produce.
  function automatic out_t apply_to_bank(in_t item);
    out_t        r;
    int unsigned s;
    int unsigned q;
    bit          every;
    r = '0;
    s = item.sensor;
    // Out-of-range index: leave the bank alone and report all zeros.
    if (s >= BANK) return r;
    case (item.op)
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          low_tab[i]  = fs_reg;
          high_tab[i] = '0;
          span_tab[i] = '0;
        end
      end
      OP_SAMPLE: begin
        if (item.raw_value < low_tab[s]) low_tab[s] = item.raw_value;
        if (item.raw_value > high_tab[s]) high_tab[s] = item.raw_value;
        // Accept the span only once the marks are far enough apart.
        if (high_tab[s] > low_tab[s] && (high_tab[s] - low_tab[s]) >= mr_reg)
          span_tab[s] = high_tab[s] - low_tab[s];
      end
      OP_NORM: begin
        if (span_tab[s] == 0) begin
          r.level = UNCAL_LEVEL;
        end else if (item.raw_value < low_tab[s]) begin
          r.level = '0;
        end else begin
          q = (32'(item.raw_value) - 32'(low_tab[s])) * 32'(fs_reg) / 32'(span_tab[s]);
          r.level = (q > 32'(fs_reg)) ? fs_reg : q[7:0];
        end
      end
      default: begin
      end
    endcase
    every = 1'b1;
    for (int i = 0; i < BANK; i++) begin
      if (span_tab[i] == 0) every = 1'b0;
    end
    r.sensor_calibrated = (span_tab[s] != 0);
    r.all_calibrated    = every;
    r.low_mark          = low_tab[s];
    r.high_mark         = high_tab[s];
    r.span              = span_tab[s];
    r.index_valid       = 1'b1;
    return r;
  endfunction

  // Build a random transaction. Most traffic is calibration and normalize on valid
  // sensors, with normalize samples pulled toward the stored marks so that the
  // below-low, exact-low and saturation edges get hit often.
  function automatic in_t next_random_item();
    in_t item;
    int  pick;
    int  v;
    int  s;
    pick = $urandom_range(99);
    s = $urandom_range(BANK - 1);
    item.sensor = SENSOR_W'(s);
    item.raw_value = 8'($urandom_range(255));
    if (pick < 2) begin
      item.op = OP_CLEAR;
    end else if (pick < 5) begin
      item.op = OP_UNUSED;
      item.sensor = SENSOR_W'($urandom_range(7));
    end else if (pick < 12) begin
      item.op = 2'($urandom_range(3));
      item.sensor = SENSOR_W'($urandom_range(7, BANK));
    end else if (pick < 45) begin
      item.op = OP_SAMPLE;
      case ($urandom_range(3))
        0:       item.raw_value = 8'($urandom_range(40));
        1:       item.raw_value = 8'($urandom_range(255, 215));
        default: item.raw_value = 8'($urandom_range(255));
      endcase
    end else begin
      item.op = OP_NORM;
      case ($urandom_range(9))
        0, 1, 2: v = int'(low_tab[s]) + $urandom_range(4) - 2;
        3, 4, 5: v = int'(low_tab[s]) + int'(span_tab[s]) + $urandom_range(6) - 3;
        default: v = $urandom_range(255);
      endcase
      item.raw_value = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    end
    return item;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one transaction; on acceptance, queue the expected result
  // (typed-in value when given, predictor otherwise). Returns at a falling edge
  // with valid still high, so the caller must drive in_valid in that same step.
  task automatic send_item(input in_t item, input bit typed, input out_t typed_result);
    out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_bank(item);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every queued result has come back,
  // then settle past the block's latency.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write a register (setup + access), then read it back and check it.
  task automatic write_register(input logic idx, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_FULL_SCALE) fs_reg = value;
    else mr_reg = value;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("prdata", {24'd0, value}, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Result side: stall at the current rate, or hold off for a counted stretch
  // when the stimulus asks for back-pressure.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation pending: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("level", want.level, out_data.level);
        check_field("sensor_calibrated", want.sensor_calibrated, out_data.sensor_calibrated);
        check_field("all_calibrated", want.all_calibrated, out_data.all_calibrated);
        check_field("low_mark", want.low_mark, out_data.low_mark);
        check_field("high_mark", want.high_mark, out_data.high_mark);
        check_field("span", want.span, out_data.span);
        check_field("index_valid", want.index_valid, out_data.index_valid);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] fs_val;
    logic [7:0] mr_val;

    // Directed table. Expected results are typed in only where they follow
    // from the preset table or a clear at a glance; other rows use the predictor.
    // Result layout: level, sensor_cal, all_cal, low, high, span, index_valid.
    directed_rows = '{
      // Preset bank: sample equal to low mark, saturation, below low, exact span.
      '{{OP_NORM,   3'd0, 8'd3},   1'b1, {8'd0,   1'b1, 1'b1, 8'd3,  8'd121, 8'd118, 1'b1}},
      '{{OP_NORM,   3'd4, 8'd255}, 1'b1, {8'd255, 1'b1, 1'b1, 8'd25, 8'd202, 8'd177, 1'b1}},
      '{{OP_NORM,   3'd2, 8'd0},   1'b1, {8'd0,   1'b1, 1'b1, 8'd5,  8'd68,  8'd63,  1'b1}},
      '{{OP_NORM,   3'd1, 8'd102}, 1'b1, {8'd255, 1'b1, 1'b1, 8'd5,  8'd102, 8'd97,  1'b1}},
      // Unused op reports the sensor untouched, level zero.
      '{{OP_UNUSED, 3'd3, 8'd200}, 1'b1, {8'd0,   1'b1, 1'b1, 8'd9,  8'd106, 8'd97,  1'b1}},
      // Out-of-range index: zeros everywhere, even for a clear; then a sample on sensor 0.
      '{{OP_CLEAR,  3'd5, 8'd0},   1'b1, '0},
      '{{OP_SAMPLE, 3'd7, 8'd255}, 1'b1, '0},
      '{{OP_NORM,   3'd6, 8'd128}, 1'b1, '0},
      '{{OP_SAMPLE, 3'd0, 8'd255}, 1'b0, '0},
      // Clear with full_scale 255, then normalize an uncalibrated sensor.
      '{{OP_CLEAR,  3'd2, 8'd0},   1'b1, {8'd0,   1'b0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b1}},
      '{{OP_NORM,   3'd3, 8'd77},  1'b1, {8'd128, 1'b0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b1}},
      // Walk sensor 0 across the min_range threshold: 49 short, 50 accepted.
      '{{OP_SAMPLE, 3'd0, 8'd100}, 1'b0, '0},
      '{{OP_SAMPLE, 3'd0, 8'd149}, 1'b0, '0},
      '{{OP_SAMPLE, 3'd0, 8'd150}, 1'b0, '0},
      '{{OP_NORM,   3'd0, 8'd125}, 1'b0, '0},
      '{{OP_NORM,   3'd0, 8'd255}, 1'b0, '0},
      // Full-width span on sensor 1.
      '{{OP_SAMPLE, 3'd1, 8'd0},   1'b0, '0},
      '{{OP_SAMPLE, 3'd1, 8'd255}, 1'b0, '0},
      '{{OP_NORM,   3'd1, 8'd254}, 1'b0, '0},
      // Calibrate the rest so the all-calibrated flag rises on the last one.
      '{{OP_SAMPLE, 3'd2, 8'd0},   1'b0, '0},
      '{{OP_SAMPLE, 3'd2, 8'd200}, 1'b0, '0},
      '{{OP_SAMPLE, 3'd3, 8'd0},   1'b0, '0},
      '{{OP_SAMPLE, 3'd3, 8'd60},  1'b0, '0},
      '{{OP_SAMPLE, 3'd4, 8'd10},  1'b0, '0},
      '{{OP_SAMPLE, 3'd4, 8'd250}, 1'b0, '0}
    };

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 57;
    foreach (directed_rows[k])
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].result);

    // Random phases. Each starts with the sender paused until every result is
    // back, so the register writes land on an idle block.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       begin fs_val = FULL_SCALE_RST; mr_val = MIN_RANGE_RST; end
        1:       begin fs_val = 8'd1;   mr_val = 8'd1;   end
        2:       begin fs_val = 8'd0;   mr_val = 8'd0;   end
        3:       begin fs_val = 8'd255; mr_val = 8'd255; end
        4:       begin fs_val = 8'd255; mr_val = 8'd0;   end
        5:       begin fs_val = 8'd0;   mr_val = 8'd255; end
        6:       begin fs_val = 8'd128; mr_val = 8'd20;  end
        default: begin
          fs_val = 8'($urandom_range(255));
          mr_val = 8'($urandom_range(255));
        end
      endcase
      write_register(REG_FULL_SCALE, fs_val);
      write_register(REG_MIN_RANGE, mr_val);

      // Idle profile: light sender gaps with heavy stalls, then the reverse,
      // then full rate.
      if (ph < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 57;
      end else if (ph < 6) begin
        send_idle_pct = 57;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Mid-phase, block the result side for a long stretch while the sender
        // keeps offering, so the block backs up and stalls its input.
        if (ph == 1 && k == PHASE_ITEMS / 2) hold_cycles = HOLD_CYCLES;
        send_item(next_random_item(), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("tb_line_sensor_calibrate_normalize_top passed");
    end else begin
      $display("tb_line_sensor_calibrate_normalize_top failed");
    end
    $finish;
  end

  // Watchdog: fail the run if it hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_line_sensor_calibrate_normalize_top failed");
    $finish;
  end

endmodule
